FILE: sv/mbbs_pkg.sv
// Shared constants for the mask bounding box statistics core.
// Field widths, configuration register indexes and default parameter values.
// No dependencies.
`default_nettype none

package mbbs_pkg;

  localparam int CoordBits    = 12;
  localparam int DepthBits    = 8;
  localparam int FaceBits     = 3;
  localparam int CountBits    = 27;
  localparam int CountOutBits = 28;

  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = 8;

  localparam logic [CfgIdxBits-1:0] CFG_CUBE_MODE  = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_FRONT_FACE = 2'd1;

endpackage

`default_nettype wire

FILE: sv/mask_bounding_box_statistics_core.sv
// Top level of the mask bounding box statistics core.
// Pixel stream in, one frame summary out, two configuration registers.
// Depends on mbbs_pkg for widths, register indexes and parameter defaults.
`default_nettype none

// One pixel is taken per beat on the slave stream and one is processed per cycle:
// a beat lands in an input register, and from there it is compared against
// the running count, box and depth range and folded into them. The beat flagged
// with tlast is folded in as well, and then the frame summary is loaded into the
// output register and the statistics are cleared, so the next frame may follow
// without a gap. The input side only stalls while a finished summary is still
// waiting in the output register and the next frame's last pixel is ready to
// replace it. An empty frame reports -1 in every field. A frame whose set pixels
// all lie off the front face reports its count, with box_valid low and -1 in the
// box and depth fields. The configuration channel is always ready, and should be
// written only while no frame is in progress.
module mask_bounding_box_statistics_core #(
  parameter int COORD_BITS = mbbs_pkg::CoordBits,
  parameter int DEPTH_BITS = mbbs_pkg::DepthBits
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,

  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire  [mbbs_pkg::CfgIdxBits-1:0]       cfg_index_i,
  input  wire  [mbbs_pkg::CfgDataBits-1:0]      cfg_data_i,

  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  // depth, pos_x, pos_y, zero padding
  input  wire  [((DEPTH_BITS+2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // face
  input  wire  [mbbs_pkg::FaceBits-1:0]         s_axis_tuser,
  input  wire                                   s_axis_tlast,

  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  // count, min_x, max_x, min_y, max_y, min_depth, max_depth, zero padding
  output logic [((mbbs_pkg::CountOutBits+4*(COORD_BITS+1)+2*(DEPTH_BITS+1)+7)/8)*8-1:0]
                                                m_axis_tdata,
  // box_valid
  output logic                                  m_axis_tuser
);

  localparam int FaceBits    = mbbs_pkg::FaceBits;
  localparam int CountBits   = mbbs_pkg::CountBits;
  localparam int CountOutW   = mbbs_pkg::CountOutBits;
  localparam int CoordOutW   = COORD_BITS + 1;
  localparam int DepthOutW   = DEPTH_BITS + 1;
  localparam int OutDataBits = CountOutW + 4 * CoordOutW + 2 * DepthOutW;
  localparam int OutTdataW   = ((OutDataBits + 7) / 8) * 8;

  // Configuration registers.
  logic                cube_mode_q;
  logic [FaceBits-1:0] front_face_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cube_mode_q  <= 1'b0;
      front_face_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mbbs_pkg::CFG_CUBE_MODE:  cube_mode_q  <= cfg_data_i[0];
        mbbs_pkg::CFG_FRONT_FACE: front_face_q <= cfg_data_i[FaceBits-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic                  in_valid_q;
  logic                  in_last_q;
  logic [DEPTH_BITS-1:0] in_depth_q;
  logic [COORD_BITS-1:0] in_x_q;
  logic [COORD_BITS-1:0] in_y_q;
  logic [FaceBits-1:0]   in_face_q;

  logic advance;
  logic consume;

  assign advance       = !in_last_q || !m_axis_tvalid || m_axis_tready;
  assign consume       = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      in_last_q  <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
      in_last_q  <= s_axis_tvalid && s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_depth_q <= s_axis_tdata[DEPTH_BITS-1:0];
      in_x_q     <= s_axis_tdata[DEPTH_BITS +: COORD_BITS];
      in_y_q     <= s_axis_tdata[DEPTH_BITS+COORD_BITS +: COORD_BITS];
      in_face_q  <= s_axis_tuser;
    end
  end

  // Running statistics.
  logic [CountBits-1:0]  count_q, count_d;
  logic [COORD_BITS-1:0] low_col_q, low_col_d, high_col_q, high_col_d;
  logic [COORD_BITS-1:0] low_row_q, low_row_d, high_row_q, high_row_d;
  logic [DEPTH_BITS-1:0] low_depth_q, low_depth_d, high_depth_q, high_depth_d;
  logic                  box_seen_q, box_seen_d;

  logic set_pixel;
  logic relevant;

  assign set_pixel = in_depth_q != '0;
  assign relevant  = !cube_mode_q || (in_face_q == front_face_q);

  always_comb begin
    count_d      = count_q;
    low_col_d    = low_col_q;
    high_col_d   = high_col_q;
    low_row_d    = low_row_q;
    high_row_d   = high_row_q;
    low_depth_d  = low_depth_q;
    high_depth_d = high_depth_q;
    box_seen_d   = box_seen_q;
    if (set_pixel) begin
      if (count_q != '1) begin
        count_d = count_q + CountBits'(1);
      end
      if (relevant) begin
        if (in_x_q < low_col_q)       low_col_d    = in_x_q;
        if (in_x_q > high_col_q)      high_col_d   = in_x_q;
        if (in_y_q < low_row_q)       low_row_d    = in_y_q;
        if (in_y_q > high_row_q)      high_row_d   = in_y_q;
        if (in_depth_q < low_depth_q) low_depth_d  = in_depth_q;
        if (in_depth_q > high_depth_q) high_depth_d = in_depth_q;
        box_seen_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      low_col_q    <= '1;
      high_col_q   <= '0;
      low_row_q    <= '1;
      high_row_q   <= '0;
      low_depth_q  <= '1;
      high_depth_q <= '0;
      box_seen_q   <= 1'b0;
    end else if (consume) begin
      if (in_last_q) begin
        count_q      <= '0;
        low_col_q    <= '1;
        high_col_q   <= '0;
        low_row_q    <= '1;
        high_row_q   <= '0;
        low_depth_q  <= '1;
        high_depth_q <= '0;
        box_seen_q   <= 1'b0;
      end else begin
        count_q      <= count_d;
        low_col_q    <= low_col_d;
        high_col_q   <= high_col_d;
        low_row_q    <= low_row_d;
        high_row_q   <= high_row_d;
        low_depth_q  <= low_depth_d;
        high_depth_q <= high_depth_d;
        box_seen_q   <= box_seen_d;
      end
    end
  end

  // Frame summary and output register.
  logic [CountOutW-1:0]   res_count;
  logic [CoordOutW-1:0]   res_min_x, res_max_x, res_min_y, res_max_y;
  logic [DepthOutW-1:0]   res_min_depth, res_max_depth;
  logic [OutDataBits-1:0] res_data;
  logic [OutTdataW-1:0]   out_data_d, out_data_q;
  logic                   out_valid_q;
  logic                   out_box_q;

  always_comb begin
    res_count = (count_d == '0) ? '1 : {{(CountOutW-CountBits){1'b0}}, count_d};
    if (box_seen_d) begin
      res_min_x     = {1'b0, low_col_d};
      res_max_x     = {1'b0, high_col_d};
      res_min_y     = {1'b0, low_row_d};
      res_max_y     = {1'b0, high_row_d};
      res_min_depth = {1'b0, low_depth_d};
      res_max_depth = {1'b0, high_depth_d};
    end else begin
      res_min_x     = '1;
      res_max_x     = '1;
      res_min_y     = '1;
      res_max_y     = '1;
      res_min_depth = '1;
      res_max_depth = '1;
    end
    res_data = {res_max_depth, res_min_depth, res_max_y, res_min_y,
                res_max_x, res_min_x, res_count};
    out_data_d = '0;
    out_data_d[OutDataBits-1:0] = res_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (consume && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && in_last_q) begin
      out_data_q <= out_data_d;
      out_box_q  <= box_seen_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_box_q;

`ifndef SYNTHESIS
  // A finished frame leaves the statistics cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && in_last_q |=> count_q == '0 && !box_seen_q && low_col_q == '1)
    else $error("statistics not cleared after frame end");

  // Once a relevant pixel is seen, the box is well ordered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    box_seen_q |-> low_col_q <= high_col_q && low_row_q <= high_row_q &&
                   low_depth_q <= high_depth_q)
    else $error("bounding box out of order");

  // A summary without a box carries -1 in its box fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[CountOutW +: CoordOutW] == '1)
    else $error("invalid box reported with real coordinates");

  // A reported count is never zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[CountOutW-1:0] != '0)
    else $error("zero count reported");

  // A pending last pixel is not dropped while a summary is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && in_last_q && m_axis_tvalid && !m_axis_tready |=> in_valid_q && in_last_q)
    else $error("last pixel lost under output stall");
`endif

endmodule

`default_nettype wire
